// ===== sv/bsfm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the balance state-feedback mixer.
`timescale 1ns / 1ps
`default_nettype none

package bsfm_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned LimW    = 31;

  // Register map of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgGainTilt       = 4'd0,
    CfgGainTiltRate   = 4'd1,
    CfgGainWheelAngle = 4'd2,
    CfgGainWheelRate  = 4'd3,
    CfgTiltBias       = 4'd4,
    CfgSpeedLimit     = 4'd5,
    CfgTurnLimit      = 4'd6,
    CfgInvWheelRadius = 4'd7
  } cfg_idx_e;

  localparam logic signed [63:0] S32Max = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32Min = 64'shFFFF_FFFF_8000_0000;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > S32Max) begin
      r = S32Max[DataW-1:0];
    end else if (v < S32Min) begin
      r = S32Min[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // Symmetric clamp to [-lim, lim]
  function automatic logic signed [DataW-1:0] clamp_sym(input logic signed [DataW-1:0] v,
                                                        input logic [LimW-1:0] lim);
    logic signed [DataW:0] l;
    logic signed [DataW:0] vv;
    logic signed [DataW:0] r;
    l  = $signed({2'b00, lim});
    vv = (DataW+1)'(v);
    if (vv > l) begin
      r = l;
    end else if (vv < -l) begin
      r = -l;
    end else begin
      r = vv;
    end
    return r[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/balance_state_feedback_mixer.sv =====
// Top level: seven-stage pipelined balance state-feedback mixer.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake            Payload
// command    in         start_i / busy_o     pitch_angle_i .. enable_i
// result     out        done_o (strobe)      left_torque_o .. active_o
// config     in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// One sample is taken every cycle; busy_o stays low.
// The stages are input, then three multiply stages (gain/reference products, wheel-rate
// product, velocity-blend product), each with an add/saturate stage after it.
// Async active-low reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds; done_o is a one-cycle strobe.

module balance_state_feedback_mixer
  import bsfm_pkg::*;
#(
  parameter int HALF_TRACK = 6554,
  parameter int FRAC_BITS  = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // command
  input  wire                        start_i,
  output logic                       busy_o,
  input  wire  signed [DataW-1:0]    pitch_angle_i,
  input  wire  signed [DataW-1:0]    pitch_rate_i,
  input  wire  signed [DataW-1:0]    yaw_rate_i,
  input  wire  signed [DataW-1:0]    left_wheel_angle_i,
  input  wire  signed [DataW-1:0]    right_wheel_angle_i,
  input  wire  signed [DataW-1:0]    left_wheel_rate_i,
  input  wire  signed [DataW-1:0]    right_wheel_rate_i,
  input  wire  signed [DataW-1:0]    speed_command_i,
  input  wire  signed [DataW-1:0]    turn_command_i,
  input  wire                        brake_i,
  input  wire                        enable_i,
  // configuration
  input  wire                        cfg_we_i,
  input  wire         [CfgIdxW-1:0]  cfg_idx_i,
  input  wire         [DataW-1:0]    cfg_wdata_i,
  // result
  output logic                       done_o,
  output logic signed [DataW-1:0]    left_torque_o,
  output logic signed [DataW-1:0]    right_torque_o,
  output logic signed [DataW-1:0]    left_speed_o,
  output logic signed [DataW-1:0]    right_speed_o,
  output logic                       active_o
);

  // 0.05 rounded to nearest at FRAC_BITS fraction bits
  localparam int VelBlendInt = ((1 << FRAC_BITS) + 10) / 20;
  localparam logic signed [24:0] VelBlend  = 25'(VelBlendInt);
  localparam logic signed [20:0] HalfTrack = 21'(HALF_TRACK);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [DataW-1:0] gain_tilt_q, gain_tilt_rate_q, gain_wheel_angle_q;
  logic signed [DataW-1:0] gain_wheel_rate_q, tilt_bias_q;
  logic        [LimW-1:0]  speed_limit_q, turn_limit_q, inv_wheel_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_tilt_q        <= -32'sd2621440;
      gain_tilt_rate_q   <= -32'sd393216;
      gain_wheel_angle_q <= -32'sd78643;
      gain_wheel_rate_q  <= -32'sd52429;
      tilt_bias_q        <= '0;
      speed_limit_q      <= 31'd65536;
      turn_limit_q       <= 31'd196608;
      inv_wheel_radius_q <= 31'd1310720;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGainTilt:       gain_tilt_q        <= $signed(cfg_wdata_i);
        CfgGainTiltRate:   gain_tilt_rate_q   <= $signed(cfg_wdata_i);
        CfgGainWheelAngle: gain_wheel_angle_q <= $signed(cfg_wdata_i);
        CfgGainWheelRate:  gain_wheel_rate_q  <= $signed(cfg_wdata_i);
        CfgTiltBias:       tilt_bias_q        <= $signed(cfg_wdata_i);
        CfgSpeedLimit:     speed_limit_q      <= cfg_wdata_i[LimW-1:0];
        CfgTurnLimit:      turn_limit_q       <= cfg_wdata_i[LimW-1:0];
        CfgInvWheelRadius: inv_wheel_radius_q <= cfg_wdata_i[LimW-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // Valid bits, one per stage; no stall, so they simply shift
  // ---------------------------------------------------------------------------
  logic [6:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: bias correction, wheel averaging, command clamp
  // ---------------------------------------------------------------------------
  logic signed [DataW:0]   ang_sum, rate_sum;
  logic signed [DataW-1:0] theta_d, vx_d, wz_d;

  assign ang_sum  = (DataW+1)'(left_wheel_angle_i) + (DataW+1)'(right_wheel_angle_i);
  assign rate_sum = (DataW+1)'(left_wheel_rate_i) + (DataW+1)'(right_wheel_rate_i);
  assign theta_d  = sat32(64'(pitch_angle_i) - 64'(tilt_bias_q));
  assign vx_d     = clamp_sym(brake_i ? '0 : speed_command_i, speed_limit_q);
  assign wz_d     = clamp_sym(brake_i ? '0 : turn_command_i, turn_limit_q);

  logic signed [DataW-1:0] s1_theta_q, s1_prate_q, s1_yaw_q, s1_phi_q, s1_phid_q;
  logic signed [DataW-1:0] s1_vx_q, s1_wz_q;
  logic                    s1_en_q;

  always_ff @(posedge clk_i) begin
    s1_theta_q <= theta_d;
    s1_prate_q <= pitch_rate_i;
    s1_yaw_q   <= yaw_rate_i;
    s1_phi_q   <= ang_sum[DataW:1];   // floor halving
    s1_phid_q  <= rate_sum[DataW:1];
    s1_vx_q    <= vx_d;
    s1_wz_q    <= wz_d;
    s1_en_q    <= enable_i;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: state-feedback products, wheel-rate reference, track offset
  // ---------------------------------------------------------------------------
  logic signed [63:0] s2_p_tilt_q, s2_p_trate_q, s2_p_wang_q, s2_p_ref_q;
  logic signed [52:0] s2_p_side_q;
  logic signed [DataW:0] s2_h_q;
  logic signed [DataW-1:0] s2_phid_q, s2_vx_q;
  logic s2_en_q;

  always_ff @(posedge clk_i) begin
    s2_p_tilt_q  <= 64'(s1_theta_q) * 64'(gain_tilt_q);
    s2_p_trate_q <= 64'(s1_prate_q) * 64'(gain_tilt_rate_q);
    s2_p_wang_q  <= 64'(s1_phi_q) * 64'(gain_wheel_angle_q);
    s2_p_ref_q   <= 64'(s1_vx_q) * 64'($signed({1'b0, inv_wheel_radius_q}));
    s2_p_side_q  <= 53'(s1_wz_q) * 53'(HalfTrack);
    s2_h_q       <= (DataW+1)'(s1_wz_q) - (DataW+1)'(s1_yaw_q);  // half differential
    s2_phid_q    <= s1_phid_q;
    s2_vx_q      <= s1_vx_q;
    s2_en_q      <= s1_en_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: wheel-rate error, partial feedback sum
  // ---------------------------------------------------------------------------
  logic signed [63:0] ref_d, psum_d;
  logic signed [DataW-1:0] err_d;

  assign ref_d  = s2_p_ref_q >>> FRAC_BITS;
  assign err_d  = sat32(64'(s2_phid_q) - ref_d);
  assign psum_d = (s2_p_tilt_q >>> FRAC_BITS) + (s2_p_trate_q >>> FRAC_BITS)
                + (s2_p_wang_q >>> FRAC_BITS);

  logic signed [63:0] s3_psum_q;
  logic signed [DataW-1:0] s3_err_q, s3_vx_q;
  logic signed [52:0] s3_side_q;
  logic signed [DataW:0] s3_h_q;
  logic s3_en_q;

  always_ff @(posedge clk_i) begin
    s3_psum_q <= psum_d;
    s3_err_q  <= err_d;
    s3_side_q <= s2_p_side_q >>> FRAC_BITS;
    s3_h_q    <= s2_h_q;
    s3_vx_q   <= s2_vx_q;
    s3_en_q   <= s2_en_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: wheel-rate error product
  // ---------------------------------------------------------------------------
  logic signed [63:0] s4_p_err_q, s4_psum_q;
  logic signed [DataW-1:0] s4_vx_q;
  logic signed [52:0] s4_side_q;
  logic signed [DataW:0] s4_h_q;
  logic s4_en_q;

  always_ff @(posedge clk_i) begin
    s4_p_err_q <= 64'(s3_err_q) * 64'(gain_wheel_rate_q);
    s4_psum_q  <= s3_psum_q;
    s4_side_q  <= s3_side_q;
    s4_h_q     <= s3_h_q;
    s4_vx_q    <= s3_vx_q;
    s4_en_q    <= s3_en_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: common torque and unsaturated wheel torques
  // ---------------------------------------------------------------------------
  logic signed [DataW-1:0] uc_d;
  assign uc_d = sat32(s4_psum_q + (s4_p_err_q >>> FRAC_BITS));

  logic signed [DataW+1:0] s5_tl_q, s5_tr_q;
  logic signed [DataW-1:0] s5_vx_q;
  logic signed [52:0] s5_side_q;
  logic s5_en_q;

  always_ff @(posedge clk_i) begin
    s5_tl_q   <= (DataW+2)'(uc_d) - (DataW+2)'(s4_h_q);
    s5_tr_q   <= (DataW+2)'(uc_d) + (DataW+2)'(s4_h_q);
    s5_side_q <= s4_side_q;
    s5_vx_q   <= s4_vx_q;
    s5_en_q   <= s4_en_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: velocity blend products
  // ---------------------------------------------------------------------------
  logic signed [58:0] s6_bl_q, s6_br_q;
  logic signed [DataW+1:0] s6_tl_q, s6_tr_q;
  logic signed [DataW-1:0] s6_vx_q;
  logic signed [52:0] s6_side_q;
  logic s6_en_q;

  always_ff @(posedge clk_i) begin
    s6_bl_q   <= 59'(s5_tl_q) * 59'(VelBlend);
    s6_br_q   <= 59'(s5_tr_q) * 59'(VelBlend);
    s6_tl_q   <= s5_tl_q;
    s6_tr_q   <= s5_tr_q;
    s6_side_q <= s5_side_q;
    s6_vx_q   <= s5_vx_q;
    s6_en_q   <= s5_en_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: output saturation, disable forces zero
  // ---------------------------------------------------------------------------
  logic signed [DataW-1:0] lt_d, rt_d, ls_d, rs_d;

  always_comb begin
    lt_d = '0;
    rt_d = '0;
    ls_d = '0;
    rs_d = '0;
    if (s6_en_q) begin
      lt_d = sat32(64'(s6_tl_q));
      rt_d = sat32(64'(s6_tr_q));
      ls_d = sat32(64'(s6_vx_q) - 64'(s6_side_q) + 64'(s6_bl_q >>> FRAC_BITS));
      rs_d = sat32(64'(s6_vx_q) + 64'(s6_side_q) + 64'(s6_br_q >>> FRAC_BITS));
    end
  end

  logic signed [DataW-1:0] lt_q, rt_q, ls_q, rs_q;
  logic act_q;

  always_ff @(posedge clk_i) begin
    lt_q  <= lt_d;
    rt_q  <= rt_d;
    ls_q  <= ls_d;
    rs_q  <= rs_d;
    act_q <= s6_en_q;
  end

  assign done_o         = vld_q[6];
  assign left_torque_o  = lt_q;
  assign right_torque_o = rt_q;
  assign left_speed_o   = ls_q;
  assign right_speed_o  = rs_q;
  assign active_o       = act_q && vld_q[6];

`ifndef SYNTHESIS
  // every accepted sample comes out of the pipeline as a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 done_o)
    else $error("sample lost in pipeline");

  // nothing comes out that was not taken in
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 7))
    else $error("result without a matching sample");

  // a disabled sample gives an all-zero result
  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !active_o) |-> (left_torque_o == '0 && right_torque_o == '0 &&
                               left_speed_o == '0 && right_speed_o == '0))
    else $error("disabled result not zero");

  a_active_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_o |-> done_o)
    else $error("active outside a result transfer");
`endif

endmodule

`default_nettype wire
